// ----- design/mh2_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helpers for the murmur2 32-bit hash core
// no dependencies
package mh2_pkg;

   localparam logic [31:0] MIX_MULT    = 32'h5bd1e995;
   localparam int          MIX_SHIFT   = 24;
   localparam int          FIN_SHIFT_A = 13;
   localparam int          FIN_SHIFT_B = 15;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_NONE,
      OP_FULL,
      OP_TAIL
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [31:0] word;
      logic [30:0] total_length;
      logic        first_item;
      logic        last_item;
   } work_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_COMBINE,
      ST_FINAL,
      ST_EMIT
   } back_state_type;

   function automatic logic [31:0] mul_mix(input logic [31:0] a);
      logic [31:0] p;
      p = a * MIX_MULT;
      return p;
   endfunction

endpackage

// ----- design/mh2_front.sv -----
`timescale 1ns / 1ps
// front end: takes requests, sorts them into full word, tail or empty, masks tail bytes
// depends on mh2_pkg
module mh2_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [31:0]           req_data_word,
   input  logic [2:0]            req_byte_count,
   input  logic [30:0]           req_total_length,
   input  logic                  req_first_item,
   input  logic                  req_last_item,
   output logic                  item_valid,
   input  logic                  item_ready,
   output mh2_pkg::work_item_type item_data
);
   import mh2_pkg::*;

   logic          valid_ff, valid_in;
   work_item_type item_ff, item_in;
   logic          accept;

   assign req_stall  = valid_ff && !item_ready;
   assign accept     = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item_data  = item_ff;

   always_comb begin
      item_in = item_ff;
      valid_in = valid_ff && !item_ready;
      if (accept) begin
         valid_in = 1'b1;
         item_in.total_length = req_total_length;
         item_in.first_item   = req_first_item;
         item_in.last_item    = req_last_item;
         item_in.word         = req_data_word;
         priority case (1'b1)
            req_byte_count == 3'd0: begin
               item_in.kind = OP_NONE;
            end
            req_byte_count >= 3'd4: begin
               item_in.kind = OP_FULL;
            end
            default: begin
               item_in.kind = OP_TAIL;
               // keep only the valid low bytes of the tail
               unique case (req_byte_count[1:0])
                  2'd1:    item_in.word = req_data_word & 32'h0000_00ff;
                  2'd2:    item_in.word = req_data_word & 32'h0000_ffff;
                  default: item_in.word = req_data_word & 32'h00ff_ffff;
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ----- design/mh2_queue.sv -----
`timescale 1ns / 1ps
// small fifo of classified work items between front and back
// depends on mh2_pkg
module mh2_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   push_ready,
   input  mh2_pkg::work_item_type push_data,
   output logic                   pop_valid,
   input  logic                   pop,
   output mh2_pkg::work_item_type pop_data
);
   import mh2_pkg::*;

   work_item_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                      do_push, do_pop;

   assign push_ready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/mh2_back.sv -----
`timescale 1ns / 1ps
// back end: running hash update, finalization and result register
// depends on mh2_pkg
module mh2_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            hash_seed,
   input  logic                   item_valid,
   output logic                   item_pop,
   input  mh2_pkg::work_item_type item_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_hash_value
);
   import mh2_pkg::*;

   back_state_type state_ff, state_in;
   logic [31:0]    hash_ff, hash_in;
   logic [31:0]    work_ff, work_in;
   logic           last_ff, last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_hash_ff, rsp_hash_in;
   logic [31:0]    start_hash;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   assign start_hash = item_data.first_item ? (hash_seed ^ {1'b0, item_data.total_length})
                                            : hash_ff;

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      work_in      = work_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hash_in  = rsp_hash_ff;
      item_pop     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               last_in  = item_data.last_item;
               unique case (item_data.kind)
                  OP_FULL: begin
                     hash_in  = start_hash;
                     work_in  = mul_mix(item_data.word);
                     state_in = ST_MIX;
                  end
                  OP_TAIL: begin
                     hash_in  = mul_mix(start_hash ^ item_data.word);
                     state_in = item_data.last_item ? ST_FINAL : ST_IDLE;
                  end
                  default: begin
                     hash_in  = start_hash;
                     state_in = item_data.last_item ? ST_FINAL : ST_IDLE;
                  end
               endcase
            end
         end
         ST_MIX: begin
            // word mix second half and hash multiply run side by side
            work_in  = mul_mix(work_ff ^ (work_ff >> MIX_SHIFT));
            hash_in  = mul_mix(hash_ff);
            state_in = ST_COMBINE;
         end
         ST_COMBINE: begin
            hash_in  = hash_ff ^ work_ff;
            state_in = last_ff ? ST_FINAL : ST_IDLE;
         end
         ST_FINAL: begin
            work_in  = mul_mix(hash_ff ^ (hash_ff >> FIN_SHIFT_A));
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = work_ff ^ (work_ff >> FIN_SHIFT_B);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff     <= work_in;
      last_ff     <= last_in;
      rsp_hash_ff <= rsp_hash_in;
   end

endmodule

// ----- design/murmur2_hash_32_core.sv -----
`timescale 1ns / 1ps
// top level of the murmur2 32-bit hash core: seed register, front, queue, back
// depends on mh2_pkg, mh2_front, mh2_queue, mh2_back
// Computes 32-bit MurmurHash2 over a message sent as little-endian words, one request
// per word. A request with first_item restarts the hash from seed xor total_length; full
// words go through word multiply, mix multiply with hash multiply, and combine in the
// back end, a tail or empty word is folded in directly, and a last request adds finalization
// before the hash shows on rsp_. The back end takes a new word only from its idle state.
// The front register and a two-entry queue let requests keep flowing while the back end
// works or the response waits. csr_ writes the seed; write it only while the core is idle.
module murmur2_hash_32_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_hash_seed,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic [30:0] req_total_length,
   input  logic        req_first_item,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);
   import mh2_pkg::*;

   logic [31:0]   hash_seed_ff, hash_seed_in;
   logic          front_valid, queue_ready;
   work_item_type front_item;
   logic          queue_valid, queue_pop;
   work_item_type queue_item;

   assign csr_ready    = 1'b1;
   assign hash_seed_in = (csr_valid && csr_ready) ? csr_hash_seed : hash_seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_seed_ff <= '0;
      end else begin
         hash_seed_ff <= hash_seed_in;
      end
   end

   mh2_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_word    (req_data_word),
      .req_byte_count   (req_byte_count),
      .req_total_length (req_total_length),
      .req_first_item   (req_first_item),
      .req_last_item    (req_last_item),
      .item_valid       (front_valid),
      .item_ready       (queue_ready),
      .item_data        (front_item)
   );

   mh2_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_ready (queue_ready),
      .push_data  (front_item),
      .pop_valid  (queue_valid),
      .pop        (queue_pop),
      .pop_data   (queue_item)
   );

   mh2_back u_back (
      .clock          (clock),
      .reset          (reset),
      .hash_seed      (hash_seed_ff),
      .item_valid     (queue_valid),
      .item_pop       (queue_pop),
      .item_data      (queue_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

// ----- design/mh2_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for murmur2_hash_32_core, bound to the top level
// depends on murmur2_hash_32_core
module mh2_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_ready,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_hash_value
);

   // a held response keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hash_value))
      else $error("held response changed");

   // nothing comes out right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid just after reset");

   // front register is empty right after reset
   assert property (@(posedge clock) $past(reset) |-> !req_stall)
      else $error("request stalled just after reset");

   // seed register always takes writes
   assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr port not ready");

endmodule

bind murmur2_hash_32_core mh2_checker u_mh2_checker (
   .clock          (clock),
   .reset          (reset),
   .csr_ready      (csr_ready),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hash_value (rsp_hash_value)
);
